@@ hdl/dsgs_pkg.sv @@
// Shared types and constants of the dynamics spectral gain shaper.
// No dependencies; used by dsgs_cfg and dynamics_spectral_gain_shaper.
`default_nettype none

package dsgs_pkg;

   localparam int INDEX_BITS = 15;
   localparam int DIV_W      = 50;   // divider numerator and denominator width
   localparam int Q_W        = 29;   // quotient width, Q.28 ratio up to 1.0
   localparam int DIV_STEPS  = 29;   // one quotient bit per stage
   localparam int AW         = 4;    // APB address width
   localparam int DVD_W      = 25;   // width of 500*tbs
   localparam int CNT_W      = 5;

   localparam logic [1:0] REG_TBS  = 2'd0;
   localparam logic [1:0] REG_RATE = 2'd1;
   localparam logic [1:0] REG_HH   = 2'd2;

   localparam logic [15:0] TBS_RESET  = 16'd1536;
   localparam logic [17:0] RATE_RESET = 18'd48000;
   localparam logic [9:0]  HH_RESET   = 10'd65;

   localparam logic [16:0] N_SCALE  = 17'd128000;  // 500 * 256
   localparam logic [8:0]  A_SCALE  = 9'd500;
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DVD_W - 1);

   localparam logic signed [31:0] GAIN_ONE = 32'sh1000_0000;
   localparam logic [Q_W-1:0]     RATIO_ONE = Q_W'(29'h1000_0000);

   typedef struct packed {
      logic                  mode;
      logic [INDEX_BITS-1:0] bin_index;
      logic signed [31:0]    sample_value;
      logic signed [15:0]    dynamics_amount;
      logic [23:0]           pitch_period;
      logic                  last_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] scaled_value;
      logic               last_out;
   } rsp_type;

   typedef enum logic [2:0] {
      CFG_IDLE,
      CFG_SQUARE,
      CFG_SCALE,
      CFG_DIVIDE,
      CFG_FINISH
   } cfg_state_type;

   typedef enum logic [1:0] {
      GAIN_UNITY,
      GAIN_QUARTER,
      GAIN_HARM,
      GAIN_BIN
   } gain_sel_type;

   // Derived thresholds handed from the register block to the datapath
   typedef struct packed {
      logic        busy;
      logic        rate_zero;
      logic [17:0] rate;
      logic [9:0]  hh;
      logic [14:0] half;
      logic [48:0] n;
      logic [49:0] n2;
      logic [24:0] a;
      logic [26:0] a3;
      logic [26:0] a4;
      logic [28:0] a16;
      logic [29:0] a20;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] v;
      logic signed [15:0] d;
      logic               last;
      gain_sel_type       gsel;
      logic               half;
   } carry_type;

   typedef struct packed {
      carry_type        c;
      logic [Q_W-1:0]   q;
      logic [DIV_W-1:0] r;
      logic [DIV_W-1:0] den;
   } dstage_type;

endpackage

`default_nettype wire

@@ hdl/dsgs_cfg.sv @@
// APB register block and threshold precompute sequencer.
// Depends on dsgs_pkg.
`default_nettype none

module dsgs_cfg (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [dsgs_pkg::AW-1:0]  paddr,
   input  wire logic [31:0]              pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output dsgs_pkg::cfg_type             cfg
);

   logic [15:0] tbs_ff;
   logic [17:0] rate_ff;
   logic [9:0]  hh_ff;
   dsgs_pkg::cfg_state_type state_ff, state_in;
   logic        busy;
   logic        wr;
   logic [31:0] sq_ff;
   logic [48:0] n_ff;
   logic [dsgs_pkg::DVD_W-1:0] div_ff;
   logic [17:0] rem_ff;
   logic [18:0] rem_sh;
   logic        qbit;
   logic [dsgs_pkg::CNT_W-1:0] cnt_ff;
   logic [24:0] a_ff;
   logic [26:0] a3_ff, a4_ff;
   logic [28:0] a16_ff;
   logic [29:0] a20_ff;
   logic [49:0] n2_ff;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tbs_ff  <= dsgs_pkg::TBS_RESET;
         rate_ff <= dsgs_pkg::RATE_RESET;
         hh_ff   <= dsgs_pkg::HH_RESET;
      end else if (wr) begin
         case (paddr[3:2])
            dsgs_pkg::REG_TBS:  tbs_ff  <= pwdata[15:0];
            dsgs_pkg::REG_RATE: rate_ff <= pwdata[17:0];
            dsgs_pkg::REG_HH:   hh_ff   <= pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         dsgs_pkg::REG_TBS:  prdata = {16'd0, tbs_ff};
         dsgs_pkg::REG_RATE: prdata = {14'd0, rate_ff};
         dsgs_pkg::REG_HH:   prdata = {22'd0, hh_ff};
         default:            prdata = 32'd0;
      endcase
   end

   // Next state: any write restarts the precompute
   always_comb begin
      case (state_ff)
         dsgs_pkg::CFG_SQUARE: state_in = dsgs_pkg::CFG_SCALE;
         dsgs_pkg::CFG_SCALE:  state_in = dsgs_pkg::CFG_DIVIDE;
         dsgs_pkg::CFG_DIVIDE: state_in = (cnt_ff == dsgs_pkg::DIV_LAST) ?
                                          dsgs_pkg::CFG_FINISH : dsgs_pkg::CFG_DIVIDE;
         dsgs_pkg::CFG_FINISH: state_in = dsgs_pkg::CFG_IDLE;
         default:              state_in = dsgs_pkg::CFG_IDLE;
      endcase
      if (wr) state_in = dsgs_pkg::CFG_SQUARE;
   end

   always_comb begin
      case (state_ff)
         dsgs_pkg::CFG_IDLE: busy = 1'b0;
         default:            busy = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= dsgs_pkg::CFG_SQUARE;
      else       state_ff <= state_in;
   end

   // Restoring division of 500*tbs by the sample rate, one bit a cycle
   assign rem_sh = {rem_ff, div_ff[dsgs_pkg::DVD_W-1]};
   assign qbit   = rem_sh >= {1'b0, rate_ff};

   always_ff @(posedge clock) begin
      case (state_ff)
         dsgs_pkg::CFG_SQUARE: begin
            sq_ff  <= tbs_ff * tbs_ff;
            div_ff <= dsgs_pkg::DVD_W'(dsgs_pkg::A_SCALE) * dsgs_pkg::DVD_W'(tbs_ff);
            rem_ff <= 18'd0;
            cnt_ff <= '0;
         end
         dsgs_pkg::CFG_SCALE: begin
            n_ff <= sq_ff * dsgs_pkg::N_SCALE;
         end
         dsgs_pkg::CFG_DIVIDE: begin
            rem_ff <= qbit ? 18'(rem_sh - {1'b0, rate_ff}) : rem_sh[17:0];
            div_ff <= {div_ff[dsgs_pkg::DVD_W-2:0], qbit};
            cnt_ff <= cnt_ff + 1'b1;
         end
         dsgs_pkg::CFG_FINISH: begin
            a_ff   <= (rate_ff == 18'd0) ? 25'd0 : div_ff;
            a3_ff  <= (rate_ff == 18'd0) ? 27'd0 : 27'({div_ff, 1'b0}) + 27'(div_ff);
            a4_ff  <= (rate_ff == 18'd0) ? 27'd0 : {div_ff, 2'b00};
            a16_ff <= (rate_ff == 18'd0) ? 29'd0 : {div_ff, 4'b0000};
            a20_ff <= (rate_ff == 18'd0) ? 30'd0 :
                      30'({div_ff, 4'b0000}) + 30'({div_ff, 2'b00});
            n2_ff  <= {n_ff, 1'b0};
         end
         default: ;
      endcase
   end

   always_comb begin
      cfg.busy      = busy;
      cfg.rate_zero = (rate_ff == 18'd0);
      cfg.rate      = rate_ff;
      cfg.hh        = hh_ff;
      cfg.half      = tbs_ff[15:1];
      cfg.n         = n_ff;
      cfg.n2        = n2_ff;
      cfg.a         = a_ff;
      cfg.a3        = a3_ff;
      cfg.a4        = a4_ff;
      cfg.a16       = a16_ff;
      cfg.a20       = a20_ff;
   end

endmodule

`default_nettype wire

@@ hdl/dynamics_spectral_gain_shaper.sv @@
// Top level of the dynamics spectral gain shaper: gain pipeline and handshakes.
// Depends on dsgs_pkg and dsgs_cfg.
`default_nettype none

// The block scales one spectral-frame element per clock when not stalled, by a
// gain that depends on its region, index, the frame's dynamics control and
// pitch. An item passes 37 register stages from the req transfer to rsp_valid:
// three front stages (index products, threshold compares, ratio setup),
// 29 divider stages that each resolve one bit of the Q.28 ratio, four gain and
// multiply stages and the output register.
// In steady state one transfer is taken every cycle; each stage holds only
// while it is full and the stage after it holds, so bubbles close up under
// backpressure. After reset and after every register write the thresholds
// are recomputed (square, scale, 25-step divide of 500*tbs by the sample
// rate, finish); req_ready stays low during that time.
module dynamics_spectral_gain_shaper (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire dsgs_pkg::req_type       req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output dsgs_pkg::rsp_type            rsp_data,
   input  wire logic                    psel,
   input  wire logic                    penable,
   input  wire logic                    pwrite,
   input  wire logic [dsgs_pkg::AW-1:0] paddr,
   input  wire logic [31:0]             pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   localparam int NS = dsgs_pkg::DIV_STEPS;

   dsgs_pkg::cfg_type cfg;

   dsgs_cfg u_cfg (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // ---------------- stage registers ----------------
   typedef struct packed {
      logic                           mode;
      logic [dsgs_pkg::INDEX_BITS-1:0] j;
      logic signed [31:0]             v;
      logic signed [15:0]             d;
      logic [23:0]                    pitch;
      logic                           last;
      logic [32:0]                    jr;
      logic                           h_in;
      logic                           b_in;
      logic                           b_ja;
      logic                           b_lt4;
      logic                           b_lt20;
   } s1_type;

   typedef struct packed {
      dsgs_pkg::carry_type              c;
      logic                             mode;
      logic [56:0]                      x;
      logic                             h_in;
      logic                             h_zero;
      logic [dsgs_pkg::DIV_W-1:0]       bnum;
      logic [dsgs_pkg::DIV_W-1:0]       bden;
   } s2_type;

   typedef struct packed {
      dsgs_pkg::carry_type        c;
      logic [dsgs_pkg::DIV_W-1:0] num;
      logic [dsgs_pkg::DIV_W-1:0] den;
   } s3_type;

   typedef struct packed {
      dsgs_pkg::carry_type c;
      logic signed [45:0]  prod;
   } m1_type;

   typedef struct packed {
      logic signed [31:0] v;
      logic               last;
      logic               half;
      logic signed [31:0] g;
      logic signed [31:0] h;
   } m2_type;

   typedef struct packed {
      logic signed [31:0] v;
      logic               last;
      logic               half;
      logic signed [31:0] g;
      logic signed [63:0] gh;
   } m3_type;

   typedef struct packed {
      logic signed [63:0] vg;
      logic               last;
   } m4_type;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   m1_type m1_ff, m1_in;
   m2_type m2_ff, m2_in;
   m3_type m3_ff, m3_in;
   m4_type m4_ff, m4_in;
   dsgs_pkg::rsp_type  rsp_ff, rsp_in;
   dsgs_pkg::dstage_type dv_ff [NS];
   dsgs_pkg::dstage_type dv_in [NS];

   logic s1_v_ff, s2_v_ff, s3_v_ff, m1_v_ff, m2_v_ff, m3_v_ff, m4_v_ff, rsp_v_ff;
   logic dv_v_ff [NS];
   logic hold_s1, hold_s2, hold_s3, hold_m1, hold_m2, hold_m3, hold_m4, hold_out;
   logic hold_dv [NS];
   logic req_xfer;

   // ---------------- hold chain ----------------
   // A stage holds only when it is full and everything after it holds.
   assign hold_out = rsp_v_ff && !rsp_ready;
   assign hold_m4  = m4_v_ff && hold_out;
   assign hold_m3  = m3_v_ff && hold_m4;
   assign hold_m2  = m2_v_ff && hold_m3;
   assign hold_m1  = m1_v_ff && hold_m2;
   assign hold_dv[NS-1] = dv_v_ff[NS-1] && hold_m1;
   for (genvar k = 0; k < NS - 1; k++) begin : g_hold
      assign hold_dv[k] = dv_v_ff[k] && hold_dv[k+1];
   end
   assign hold_s3  = s3_v_ff && hold_dv[0];
   assign hold_s2  = s2_v_ff && hold_s3;
   assign hold_s1  = s1_v_ff && hold_s2;

   // No transfer while the thresholds are being recomputed
   assign req_ready = !cfg.busy && !hold_s1;
   assign req_xfer  = req_valid && req_ready;

   // ---------------- S1: index product, harmonic and bin compares ----------------
   always_comb begin
      s1_in.mode   = req_data.mode;
      s1_in.j      = req_data.bin_index;
      s1_in.v      = req_data.sample_value;
      s1_in.d      = req_data.dynamics_amount;
      s1_in.pitch  = req_data.pitch_period;
      s1_in.last   = req_data.last_in;
      s1_in.jr     = req_data.bin_index * cfg.rate;
      s1_in.h_in   = 16'(req_data.bin_index) < 16'(cfg.hh);
      s1_in.b_in   = (req_data.bin_index < cfg.half) && !cfg.rate_zero;
      s1_in.b_ja   = 25'(req_data.bin_index) >= cfg.a;
      s1_in.b_lt4  = 27'(req_data.bin_index) < cfg.a4;
      s1_in.b_lt20 = 30'(req_data.bin_index) < cfg.a20;
   end

   // ---------------- S2: harmonic product, bin ratio setup ----------------
   always_comb begin
      s2_in.c.v    = s1_ff.v;
      s2_in.c.d    = s1_ff.d;
      s2_in.c.last = s1_ff.last;
      s2_in.mode   = s1_ff.mode;
      s2_in.x      = s1_ff.jr * s1_ff.pitch;
      s2_in.h_in   = s1_ff.h_in;
      s2_in.h_zero = cfg.rate_zero || (s1_ff.pitch == 24'd0);
      // Bin gain: rising edge from A to 4A, falling edge from 4A to 20A
      if (s1_ff.b_lt4) begin
         s2_in.bnum = dsgs_pkg::DIV_W'(30'(s1_ff.j) - 30'(cfg.a));
         s2_in.bden = dsgs_pkg::DIV_W'(cfg.a3);
      end else begin
         s2_in.bnum = dsgs_pkg::DIV_W'(cfg.a20 - 30'(s1_ff.j));
         s2_in.bden = dsgs_pkg::DIV_W'(cfg.a16);
      end
      if (s1_ff.b_in && s1_ff.b_ja && (s1_ff.b_lt4 || s1_ff.b_lt20))
         s2_in.c.gsel = dsgs_pkg::GAIN_BIN;
      else
         s2_in.c.gsel = dsgs_pkg::GAIN_UNITY;
      // The extra 1 + d/2 factor applies, in bin mode and for negative d, to any in-range bin at or past A
      s2_in.c.half = s1_ff.mode && s1_ff.b_in && s1_ff.b_ja && s1_ff.d[15];
   end

   // ---------------- S3: harmonic threshold decision, divider operands ----------------
   always_comb begin
      s3_in.c   = s2_ff.c;
      s3_in.num = '0;
      s3_in.den = dsgs_pkg::DIV_W'(1);
      if (s2_ff.mode) begin
         if (s2_ff.c.gsel == dsgs_pkg::GAIN_BIN) begin
            s3_in.num = s2_ff.bnum;
            s3_in.den = s2_ff.bden;
         end
      end else if (!s2_ff.h_in) begin
         s3_in.c.gsel = dsgs_pkg::GAIN_UNITY;
      end else if (s2_ff.h_zero || (s2_ff.x < 57'(cfg.n))) begin
         // Below the first threshold, or pitch treated as infinitely long
         s3_in.c.gsel = dsgs_pkg::GAIN_QUARTER;
      end else if (s2_ff.x < 57'(cfg.n2)) begin
         s3_in.c.gsel = dsgs_pkg::GAIN_HARM;
         s3_in.num    = dsgs_pkg::DIV_W'(s2_ff.x - 57'(cfg.n));
         s3_in.den    = dsgs_pkg::DIV_W'(cfg.n);
      end else begin
         s3_in.c.gsel = dsgs_pkg::GAIN_UNITY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         if (!hold_s1) s1_v_ff <= req_xfer;
         if (!hold_s2) s2_v_ff <= s1_v_ff;
         if (!hold_s3) s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold_s1) s1_ff <= s1_in;
      if (!hold_s2) s2_ff <= s2_in;
      if (!hold_s3) s3_ff <= s3_in;
   end

   // ---------------- divider: one ratio bit per stage ----------------
   for (genvar k = 0; k < NS; k++) begin : g_div
      dsgs_pkg::dstage_type prev;
      logic                 prev_v;
      logic [dsgs_pkg::DIV_W:0] rs;
      logic                 ge;

      if (k == 0) begin : g_first
         always_comb begin
            prev.c   = s3_ff.c;
            prev.q   = '0;
            prev.r   = s3_ff.num;
            prev.den = s3_ff.den;
            prev_v   = s3_v_ff;
            rs       = {1'b0, s3_ff.num};
         end
      end else begin : g_rest
         always_comb begin
            prev   = dv_ff[k-1];
            prev_v = dv_v_ff[k-1];
            rs     = {dv_ff[k-1].r, 1'b0};
         end
      end

      always_comb begin
         ge        = rs >= {1'b0, prev.den};
         dv_in[k]  = prev;
         dv_in[k].q = {prev.q[dsgs_pkg::Q_W-2:0], ge};
         dv_in[k].r = ge ? dsgs_pkg::DIV_W'(rs - {1'b0, prev.den})
                         : rs[dsgs_pkg::DIV_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) dv_v_ff[k] <= 1'b0;
         else if (!hold_dv[k]) dv_v_ff[k] <= prev_v;
      end

      always_ff @(posedge clock) begin
         if (!hold_dv[k]) dv_ff[k] <= dv_in[k];
      end
   end

   // ---------------- M1: d times ratio ----------------
   always_comb begin
      m1_in.c    = dv_ff[NS-1].c;
      m1_in.prod = 46'(dv_ff[NS-1].c.d) * 46'($signed({1'b0, dv_ff[NS-1].q}));
   end

   // ---------------- M2: gain selection ----------------
   always_comb begin
      m2_in.v    = m1_ff.c.v;
      m2_in.last = m1_ff.c.last;
      m2_in.half = m1_ff.c.half;
      m2_in.h    = dsgs_pkg::GAIN_ONE + $signed({{3{m1_ff.c.d[15]}}, m1_ff.c.d, 13'd0});
      case (m1_ff.c.gsel)
         dsgs_pkg::GAIN_QUARTER:
            m2_in.g = dsgs_pkg::GAIN_ONE + $signed({{4{m1_ff.c.d[15]}}, m1_ff.c.d, 12'd0});
         dsgs_pkg::GAIN_HARM:
            m2_in.g = dsgs_pkg::GAIN_ONE + 32'(m1_ff.prod >>> 16);
         dsgs_pkg::GAIN_BIN:
            m2_in.g = dsgs_pkg::GAIN_ONE - 32'(m1_ff.prod >>> 14);
         default:
            m2_in.g = dsgs_pkg::GAIN_ONE;
      endcase
   end

   // ---------------- M3: gain times half factor ----------------
   always_comb begin
      m3_in.v    = m2_ff.v;
      m3_in.last = m2_ff.last;
      m3_in.half = m2_ff.half;
      m3_in.g    = m2_ff.g;
      m3_in.gh   = m2_ff.g * m2_ff.h;
   end

   // ---------------- M4: value times gain ----------------
   logic signed [31:0] g_final;
   assign g_final = m3_ff.half ? 32'(m3_ff.gh >>> 28) : m3_ff.g;

   always_comb begin
      m4_in.vg   = m3_ff.v * g_final;
      m4_in.last = m3_ff.last;
   end

   // ---------------- output: round half up, saturate ----------------
   logic signed [63:0] rnd;
   always_comb begin
      rnd = (m4_ff.vg + 64'sd134217728) >>> 28;
      if (rnd > 64'sd2147483647)
         rsp_in.scaled_value = 32'sh7FFF_FFFF;
      else if (rnd < -64'sd2147483648)
         rsp_in.scaled_value = 32'sh8000_0000;
      else
         rsp_in.scaled_value = rnd[31:0];
      rsp_in.last_out = m4_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff  <= 1'b0;
         m2_v_ff  <= 1'b0;
         m3_v_ff  <= 1'b0;
         m4_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (!hold_m1)  m1_v_ff  <= dv_v_ff[NS-1];
         if (!hold_m2)  m2_v_ff  <= m1_v_ff;
         if (!hold_m3)  m3_v_ff  <= m2_v_ff;
         if (!hold_m4)  m4_v_ff  <= m3_v_ff;
         if (!hold_out) rsp_v_ff <= m4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (!hold_m1)  m1_ff  <= m1_in;
      if (!hold_m2)  m2_ff  <= m2_in;
      if (!hold_m3)  m3_ff  <= m3_in;
      if (!hold_m4)  m4_ff  <= m4_in;
      if (!hold_out) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   // ---------------- assertions ----------------
   // Items must not enter while thresholds are stale
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      cfg.busy |-> !req_ready)
      else $error("transfer accepted during threshold recompute");

   // Every ratio set up at S3 has num <= den, so the quotient never exceeds one
   a_ratio_range: assert property (@(posedge clock) disable iff (reset)
      dv_v_ff[NS-1] |-> (dv_ff[NS-1].q <= dsgs_pkg::RATIO_ONE))
      else $error("divider ratio above one");

   // A held output stage keeps the pipeline tail from advancing
   a_tail_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_v_ff && !rsp_ready && m4_v_ff) |=> m4_v_ff)
      else $error("tail stage dropped while output stalled");

endmodule

`default_nettype wire
